>>> src/pedd_pkg.sv
// ----------------------------------------------------------------------------
// Palette dither package
// Shared types, constants and a helper function for the palette ditherer.
// ----------------------------------------------------------------------------
package pedd_pkg;

  localparam int unsigned PaletteSize = 256;
  localparam int unsigned MaxWidth    = 2048;
  localparam int unsigned PalAw       = $clog2(PaletteSize);
  localparam int unsigned ColAw       = $clog2(MaxWidth);
  localparam int unsigned ColW        = ColAw + 1;
  localparam int unsigned WidthW      = 12;
  localparam int unsigned ThrW        = 18;
  localparam int unsigned CfgDataW    = 18;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned ErrW        = 9;
  localparam int unsigned DistW       = 18;
  localparam logic [DistW-1:0] DistInit = DistW'(255 * 255 * 4 + 1);

  localparam logic [CfgIdxW-1:0] CfgImageWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 1'b1;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdDither = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       start_of_image;
  } in_req_t;

  typedef struct packed {
    logic [7:0] palette_index;
  } out_req_t;

  typedef logic signed [ErrW-1:0] err_t;
  typedef err_t [3:0] err4_t;

  // Search request and answer between the control and the search unit.
  typedef struct packed {
    logic             start;
    logic [3:0][7:0]  pix;
  } srch_req_t;

  typedef struct packed {
    logic             done;
    logic [PalAw-1:0] best;
  } srch_rsp_t;

  // Floor of err*w/16, then add and clamp to 0..255.
  function automatic logic [7:0] add_clamp(input logic [7:0] v, input err_t e,
                                           input logic [2:0] w);
    logic signed [12:0] p;
    logic signed [12:0] s;
    begin
      p = 13'(e) * $signed({10'd0, w});
      s = 13'($signed({5'd0, v})) + (p >>> 4);
      if (s < 0) begin
        add_clamp = 8'd0;
      end else if (s > 13'sd255) begin
        add_clamp = 8'd255;
      end else begin
        add_clamp = s[7:0];
      end
    end
  endfunction

endpackage

>>> src/pedd_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface pedd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pedd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pedd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/pedd_search.sv
// ----------------------------------------------------------------------------
// Palette search
// Streams palette entries one per cycle and tracks the nearest one; a new best under the threshold ends the search.
// ----------------------------------------------------------------------------
module pedd_search import pedd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srch_req_t         req_i,
  input  logic [ThrW-1:0]   thr_i,
  input  logic [31:0]       pal_rdata_i,
  output logic [PalAw-1:0]  pal_raddr_o,
  output srch_rsp_t         rsp_o
);
  localparam int unsigned CntW = PalAw + 1;

  logic              run_q, run_d;
  logic              vld_q, vld_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PalAw-1:0]  idx_q, idx_d;
  logic [DistW-1:0]  bestd_q, bestd_d;
  logic [PalAw-1:0]  best_q, best_d;
  logic [3:0][7:0]   pix_q;
  logic              done_q, done_d;
  logic [DistW-1:0]  sq_dist;
  logic [8:0]        df [4];
  logic              hit;
  logic              early;
  logic              last_entry;

  always_comb begin
    sq_dist = '0;
    for (int c = 0; c < 4; c++) begin
      df[c] = {1'b0, pix_q[c]} - {1'b0, pal_rdata_i[8*c +: 8]};
      if (df[c][8]) begin
        df[c] = -df[c];
      end
      sq_dist = sq_dist + DistW'(df[c][7:0] * df[c][7:0]);
    end
  end

  assign hit        = vld_q && (sq_dist < bestd_q);
  assign early      = hit && (DistW'(sq_dist) < DistW'(thr_i));
  assign last_entry = vld_q && (idx_q == PalAw'(PaletteSize - 1));

  always_comb begin
    run_d   = run_q;
    vld_d   = 1'b0;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    bestd_d = bestd_q;
    best_d  = best_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      run_d   = 1'b1;
      vld_d   = 1'b1;
      cnt_d   = CntW'(1);
      idx_d   = '0;
      bestd_d = DistInit;
      best_d  = '0;
    end else if (run_q) begin
      if (hit) begin
        bestd_d = sq_dist;
        best_d  = idx_q;
      end
      if (early || last_entry) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        vld_d = 1'b1;
        idx_d = cnt_q[PalAw-1:0];
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign pal_raddr_o = req_i.start ? '0 : cnt_q[PalAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    idx_q   <= idx_d;
    bestd_q <= bestd_d;
    best_q  <= best_d;
    if (req_i.start) begin
      pix_q <= req_i.pix;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.best = best_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("search done while running");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !req_i.start) else $error("search restarted while busy");
  a_vld_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> run_q) else $error("entry valid outside a search");
endmodule

>>> src/palette_error_diffusion_dither_top.sv
// ----------------------------------------------------------------------------
// Palette error-diffusion ditherer
// Floyd-Steinberg dithering of RGBA pixels onto a loaded 256-entry palette.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   command, entry_index, red, green, blue, alpha, start_of_image
// out_if    out  palette_index
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// A pixel searches the palette entries in turn via the single palette read port.
// Reset clears control state; the palette and row memories keep no reset.
// The output register frees the input side; the next pixel waits for the
// previous result to leave only when it reaches its own output.
module palette_error_diffusion_dither_top import pedd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pedd_if.sink                in_if,
  pedd_if.source              out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StRead   = 6'b000010,
    StDiff   = 6'b000100,
    StSearch = 6'b001000,
    StFetch  = 6'b010000,
    StWrite  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [WidthW-1:0] width_q;
  logic [ThrW-1:0]   thr_q;
  logic [ColW-1:0]   weff;
  logic [ColW-1:0]   col_q, col_d;
  logic              first_q, first_d;
  err4_t             left_q, left_d, al_q, al_d;
  logic [3:0][7:0]   pix_q, pix_d;
  logic              c0_q, c0_d, last_q, last_d;
  logic [ColAw-1:0]  cur_q, cur_d;
  logic [PalAw-1:0]  k_q, k_d;
  logic              ov_q, ov_d;
  logic [7:0]        ox_q, ox_d;
  in_req_t           req;

  logic              pal_we;
  logic [PalAw-1:0]  pal_raddr, srch_raddr;
  logic [31:0]       pal_rdata;
  logic              row_we;
  logic [ColAw-1:0]  row_raddr;
  logic [4*ErrW-1:0] row_rdata, row_wdata;
  logic [4*ErrW-1:0] above_q, above_d;
  srch_req_t         sreq;
  srch_rsp_t         srsp;
  logic [ColW-1:0]   c;
  logic              rd_cycle;

  assign req = in_if.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(640);
      thr_q   <= ThrW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth: width_q <= cfg_data_i[WidthW-1:0];
        CfgThreshold:  thr_q   <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < WidthW'(2)) begin
      weff = ColW'(2);
    end else if (width_q > WidthW'(MaxWidth)) begin
      weff = ColW'(MaxWidth);
    end else begin
      weff = ColW'(width_q);
    end
  end

  pedd_ram #(.Width(32), .Depth(PaletteSize)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (req.entry_index[PalAw-1:0]),
    .wdata_i ({req.alpha, req.blue, req.green, req.red}),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  pedd_ram #(.Width(4*ErrW), .Depth(MaxWidth)) u_row (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (cur_q),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  pedd_search u_srch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (sreq),
    .thr_i       (thr_q),
    .pal_rdata_i (pal_rdata),
    .pal_raddr_o (srch_raddr),
    .rsp_o       (srsp)
  );

  assign in_if.ready  = (state_q == StIdle);
  assign out_if.valid = ov_q;
  assign out_if.data.palette_index = ox_q;
  assign pal_we = in_if.valid && in_if.ready && (req.command == CmdLoad);
  assign pal_raddr = ((state_q == StFetch) || (state_q == StWrite)) ? k_q : srch_raddr;

  always_comb begin
    c = col_q;
    if (req.start_of_image) begin
      c = '0;
    end
    if (c >= weff) begin
      c = '0;
    end
  end

  assign rd_cycle = (state_q == StIdle);
  assign row_raddr = rd_cycle ? c[ColAw-1:0] : ColAw'(cur_q + ColAw'(1));

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    first_d = first_q;
    left_d  = left_q;
    al_d    = al_q;
    pix_d   = pix_q;
    c0_d    = c0_q;
    last_d  = last_q;
    cur_d   = cur_q;
    k_d     = k_q;
    above_d = above_q;
    ov_d    = ov_q && !out_if.ready;
    ox_d    = ox_q;
    sreq    = '0;
    row_we  = 1'b0;
    row_wdata = '0;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid && in_if.ready && req.command == CmdDither) begin
          first_d = req.start_of_image ? 1'b1 : first_q;
          if (!req.start_of_image && col_q >= weff) begin
            first_d = 1'b0;
          end
          pix_d  = {req.alpha, req.blue, req.green, req.red};
          c0_d   = (c == '0);
          last_d = ((c + ColW'(1)) >= weff);
          cur_d  = c[ColAw-1:0];
          state_d = StRead;
        end
      end
      StRead: begin
        above_d = row_rdata;
        state_d = StDiff;
      end
      StDiff: begin
        for (int ch = 0; ch < 4; ch++) begin
          if (!first_q) begin
            if (!c0_q) begin
              pix_d[ch] = add_clamp(pix_d[ch], al_q[ch], 3'd1);
            end
            pix_d[ch] = add_clamp(pix_d[ch], err_t'(above_q[ErrW*ch +: ErrW]), 3'd5);
            if (!last_q) begin
              pix_d[ch] = add_clamp(pix_d[ch], err_t'(row_rdata[ErrW*ch +: ErrW]), 3'd3);
            end
          end
          if (!c0_q) begin
            pix_d[ch] = add_clamp(pix_d[ch], left_q[ch], 3'd7);
          end
        end
        sreq.start = 1'b1;
        sreq.pix   = pix_d;
        state_d = StSearch;
      end
      StSearch: begin
        if (srsp.done) begin
          k_d = srsp.best;
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StWrite;
      end
      StWrite: begin
        if (!ov_q || out_if.ready) begin
          for (int ch = 0; ch < 4; ch++) begin
            left_d[ch] = err_t'({1'b0, pix_q[ch]} - {1'b0, pal_rdata[8*ch +: 8]});
            row_wdata[ErrW*ch +: ErrW] = left_d[ch];
            al_d[ch] = err_t'(above_q[ErrW*ch +: ErrW]);
          end
          row_we = 1'b1;
          ov_d = 1'b1;
          ox_d = 8'(k_q);
          if (last_q) begin
            col_d = '0;
            first_d = 1'b0;
          end else begin
            col_d = ColW'(cur_q) + ColW'(1);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
      al_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      first_q <= first_d;
      left_q  <= left_d;
      al_q    <= al_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q   <= pix_d;
    c0_q    <= c0_d;
    last_q  <= last_d;
    cur_q   <= cur_d;
    k_q     <= k_d;
    above_q <= above_d;
    ox_q    <= ox_d;
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite && state_d == StIdle) |=> (col_q < weff))
    else $error("column past width after a pixel");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> ov_q) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready) else $error("ready while busy");
endmodule

>>> sim/palette_error_diffusion_dither_top_tb.sv
// ----------------------------------------------------------------------------
// Palette ditherer testbench
// Loads palettes and streams RGBA pixels through the ditherer. A behavioral
// predictor with its own palette and error rows computes the expected palette
// index for every pixel request, and a scoreboard compares the results.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_top_tb;
  import pedd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class index_scoreboard;
    logic [7:0] expected_idx[$];
    int unsigned mismatches;

    function void note_pixel(logic [7:0] idx);
      expected_idx.push_back(idx);
    endfunction

    function void check_result(logic [7:0] actual);
      logic [7:0] want;
      if (expected_idx.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: index %0d", actual);
        return;
      end
      want = expected_idx.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("palette_index mismatch: expected %0d, actual %0d", want, actual);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgImageWidth;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pedd_if #(.T(in_req_t)) in_if ();
  pedd_if #(.T(out_req_t)) out_if ();

  palette_error_diffusion_dither_top dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  index_scoreboard sb = new();

  // Predictor state.
  logic [7:0] pal_rgba[PaletteSize][4];
  int row_err[MaxWidth][4];
  int left_err[4];
  int above_left[4];
  int unsigned col_count;
  bit first_row;
  int unsigned width_reg;
  int unsigned thr_reg;
  bit [PaletteSize-1:0] pal_loaded;
  int unsigned images_started;

  int unsigned hold_cycles;

  function automatic int diffuse(int v, int e, int w);
    int p;
    int s;
    p = e * w;
    s = v + ((p >= 0) ? p / 16 : -((-p + 15) / 16));
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s;
  endfunction

  function automatic logic [7:0] nearest_entry(int v[4]);
    int best;
    int bestd;
    int d;
    int e;
    best = 0;
    bestd = 255 * 255 * 4 + 1;
    for (int i = 0; i < PaletteSize; i++) begin
      d = 0;
      for (int ch = 0; ch < 4; ch++) begin
        e = v[ch] - int'(pal_rgba[i][ch]);
        d += e * e;
      end
      if (d < bestd) begin
        bestd = d;
        best = i;
        if (bestd < int'(thr_reg)) break;
      end
    end
    return best[7:0];
  endfunction

  function automatic void predict(in_req_t r);
    int v[4];
    int unsigned w;
    int unsigned c;
    logic [7:0] k;
    v[0] = int'(r.red); v[1] = int'(r.green); v[2] = int'(r.blue); v[3] = int'(r.alpha);
    if (r.command == CmdLoad) begin
      for (int ch = 0; ch < 4; ch++) pal_rgba[r.entry_index][ch] = v[ch][7:0];
      pal_loaded[r.entry_index] = 1'b1;
      return;
    end
    w = width_reg < 2 ? 2 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    if (r.start_of_image) begin
      col_count = 0;
      first_row = 1'b1;
    end
    if (col_count >= w) begin
      col_count = 0;
      first_row = 1'b0;
    end
    c = col_count;
    for (int ch = 0; ch < 4; ch++) begin
      if (!first_row) begin
        if (c > 0) v[ch] = diffuse(v[ch], above_left[ch], 1);
        v[ch] = diffuse(v[ch], row_err[c][ch], 5);
        if (c + 1 < w) v[ch] = diffuse(v[ch], row_err[c + 1][ch], 3);
      end
      if (c > 0) v[ch] = diffuse(v[ch], left_err[ch], 7);
    end
    k = nearest_entry(v);
    for (int ch = 0; ch < 4; ch++) begin
      above_left[ch] = row_err[c][ch];
      row_err[c][ch] = v[ch] - int'(pal_rgba[k][ch]);
      left_err[ch] = row_err[c][ch];
    end
    col_count = c + 1;
    if (col_count >= w) begin
      col_count = 0;
      first_row = 1'b0;
    end
    sb.note_pixel(k);
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) predict(in_if.data);
    if (out_if.valid && out_if.ready) sb.check_result(out_if.data.palette_index);
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      out_if.ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
    end else if (!out_if.ready) begin
      out_if.ready <= ($urandom_range(0, 4) == 0) ? 1'b1 : 1'b0;
    end
  end

  task automatic send(in_req_t r, bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= r;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_entry(int idx, int rr, int gg, int bb, int aa);
    in_req_t r;
    r = '{command: CmdLoad, entry_index: idx[7:0], red: rr[7:0], green: gg[7:0],
          blue: bb[7:0], alpha: aa[7:0], start_of_image: 1'($urandom_range(0, 1))};
    send(r);
  endtask

  task automatic pixel(bit sof, int rr, int gg, int bb, int aa, bit no_gap = 0);
    in_req_t r;
    r = '{command: CmdDither, entry_index: 8'($urandom), red: rr[7:0], green: gg[7:0],
          blue: bb[7:0], alpha: aa[7:0], start_of_image: sof};
    send(r, no_gap);
    if (sof) images_started++;
  endtask

  task automatic drain();
    stop_sending();
    while (sb.expected_idx.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgImageWidth) width_reg = val & 12'hFFF;
    else thr_reg = val & 18'h3FFFF;
  endtask

  task automatic load_full_palette(bit gray);
    for (int i = 0; i < PaletteSize; i++) begin
      if (gray) load_entry(i, i, i, i, 255 - i);
      else load_entry(i, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Pixels per image are chosen so that every row error that is read was
  // written in the same image (a full first row always precedes row two).
  task automatic random_image(int unsigned w, int unsigned n);
    for (int unsigned p = 0; p < n; p++)
      pixel(p == 0, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned w;
    width_reg = 640;
    thr_reg = 10;
    col_count = 0;
    first_row = 1'b1;
    hold_cycles = 0;
    images_started = 0;
    pal_loaded = '0;
    for (int i = 0; i < 4; i++) begin
      left_err[i] = 0;
      above_left[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full palette first so no unwritten entry is ever read.
    write_reg(CfgImageWidth, 2);
    write_reg(CfgThreshold, 0);
    load_full_palette(1);
    load_entry(0, 0, 0, 0, 0);
    load_entry(255, 255, 255, 255, 255);
    load_entry(7, 'h80, 'h80, 'h80, 'h80);
    load_entry(8, 'h80, 'h80, 'h80, 'h80);
    pixel(1, 0, 0, 0, 0);
    pixel(0, 255, 255, 255, 255);
    pixel(0, 'h80, 'h80, 'h80, 'h80);
    pixel(0, 255, 0, 255, 0);
    pixel(0, 0, 255, 0, 255);
    pixel(1, 'h80, 'h80, 'h80, 'h80);
    pixel(0, 'h55, 'hAA, 'h55, 'hAA);
    pixel(0, 'hAA, 'h55, 'hAA, 'h55);
    drain();

    // Width lowered mid-row: row ends early.
    write_reg(CfgImageWidth, 5);
    write_reg(CfgThreshold, 260101);
    for (int p = 0; p < 8; p++) pixel(p == 0, $urandom, $urandom, $urandom, $urandom);
    drain();
    write_reg(CfgImageWidth, 3);
    for (int p = 0; p < 4; p++) pixel(0, $urandom, $urandom, $urandom, $urandom);
    drain();
    // Width register below minimum acts as two.
    write_reg(CfgImageWidth, 0);
    for (int p = 0; p < 6; p++) pixel(p == 0, $urandom, $urandom, $urandom, $urandom);
    drain();

    // Receiver holds off long while sender keeps offering.
    write_reg(CfgThreshold, 100);
    write_reg(CfgImageWidth, 4);
    fork
      hold_cycles = 2000;
      for (int p = 0; p < 12; p++) pixel(p == 0, $urandom, $urandom, $urandom, $urandom, 1);
    join
    drain();

    // Out-of-range width (clamped to MaxWidth) with a partial row, then MaxWidth written alone.
    write_reg(CfgImageWidth, 4095);
    write_reg(CfgThreshold, 1000);
    for (int p = 0; p < 20; p++) pixel(p == 0, $urandom, $urandom, $urandom, $urandom);
    drain();
    write_reg(CfgImageWidth, 2048);
    drain();

    // Random phases.
    for (int ph = 0; ph < 16; ph++) begin
      w = $urandom_range(2, 12);
      write_reg(CfgImageWidth, w);
      case (ph % 4)
        0: write_reg(CfgThreshold, 0);
        1: write_reg(CfgThreshold, 260101);
        2: write_reg(CfgThreshold, $urandom_range(1, 4000));
        default: write_reg(CfgThreshold, $urandom_range(0, 262143));
      endcase
      if (ph % 3 == 0) begin
        for (int i = 0; i < 40; i++)
          load_entry($urandom_range(0, 255), $urandom, $urandom, $urandom, $urandom);
      end
      for (int im = 0; im < 4; im++) random_image(w, $urandom_range(w, 4 * w + 3));
      // Sender pauses until all results have come.
      if (ph == 5) begin
        stop_sending();
        while (sb.expected_idx.size() != 0) @(posedge clk_i);
      end
      drain();
    end
    drain();
    if (sb.mismatches == 0 && sb.expected_idx.size() == 0)
      $display("palette_error_diffusion_dither_top_tb: done, clean");
    else
      $display("palette_error_diffusion_dither_top_tb: done, errors");
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("palette_error_diffusion_dither_top_tb: done, errors");
    $finish;
  end
endmodule
